// ===== rtl/fpe_pkg.sv =====
// Shared types, constants and helpers for the format print engine.
// Used by fpe_numconv and format_print_engine; depends on nothing else.
package fpe_pkg;

  localparam int INT_BITS = 32;
  localparam int PTR_BITS = 64;
  localparam int ARG_W    = 64;
  localparam int CHAR_W   = 8;
  localparam int TOTAL_W  = 31;
  localparam int FUNC_W   = 2;

  localparam int IN_TDATA_W  = 72;  // byte_in + arg_word
  localparam int OUT_TDATA_W = 40;  // out_char + char_total + pad
  localparam int OUT_TUSER_W = 3;

  // digit counts of each number format
  localparam int DEC_DIGITS  = (INT_BITS * 30103) / 100000 + 1;
  localparam int OCT_DIGITS  = (INT_BITS + 2) / 3;
  localparam int HEXI_DIGITS = (INT_BITS + 3) / 4;
  localparam int HEXP_DIGITS = (PTR_BITS + 3) / 4;

  localparam int DEC_W  = 4 * DEC_DIGITS;
  localparam int OCT_W  = 3 * OCT_DIGITS;
  localparam int HEXI_W = 4 * HEXI_DIGITS;
  localparam int HEXP_W = 4 * HEXP_DIGITS;
  localparam int DAB_W  = DEC_W + INT_BITS;  // BCD field on top of the binary field

  localparam int NUM_W_A = (DAB_W > HEXP_W) ? DAB_W : HEXP_W;
  localparam int NUM_W_B = (OCT_W > HEXI_W) ? OCT_W : HEXI_W;
  localparam int NUM_W   = (NUM_W_A > NUM_W_B) ? NUM_W_A : NUM_W_B;

  localparam int DIG_A   = (DEC_DIGITS > OCT_DIGITS) ? DEC_DIGITS : OCT_DIGITS;
  localparam int DIG_B   = (HEXI_DIGITS > HEXP_DIGITS) ? HEXI_DIGITS : HEXP_DIGITS;
  localparam int MAX_DIG = (DIG_A > DIG_B) ? DIG_A : DIG_B;
  localparam int CNT_MAX = (INT_BITS > MAX_DIG) ? INT_BITS : MAX_DIG;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // item kinds on in_tuser
  localparam logic [FUNC_W-1:0] FUNC_FMT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ARG = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_STR = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CH_C     = 8'h63;  // 'c'
  localparam logic [CHAR_W-1:0] CH_D     = 8'h64;  // 'd'
  localparam logic [CHAR_W-1:0] CH_I     = 8'h69;  // 'i'
  localparam logic [CHAR_W-1:0] CH_U     = 8'h75;  // 'u'
  localparam logic [CHAR_W-1:0] CH_O     = 8'h6F;  // 'o'
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;  // 'x'
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;  // 'X'
  localparam logic [CHAR_W-1:0] CH_P     = 8'h70;  // 'p'
  localparam logic [CHAR_W-1:0] CH_S     = 8'h73;  // 's'

  typedef enum logic [2:0] {PM_IDLE, PM_PCT, PM_ARG, PM_STR} parse_mode_t;

  typedef enum logic [2:0] {
    CV_NONE, CV_CHR, CV_DEC, CV_UNS, CV_OCT, CV_HEX, CV_HEXU, CV_PTR
  } conv_t;

  typedef enum logic [2:0] {NK_DEC, NK_OCT, NK_HEXL, NK_HEXU, NK_PTR} num_kind_t;

  typedef enum logic [1:0] {ST_IN, ST_CHR, ST_NUM} top_state_t;

  typedef enum logic [1:0] {NC_IDLE, NC_DABBLE, NC_OUT} nc_state_t;

  typedef struct packed {
    logic      load;
    num_kind_t kind;
  } fpe_num_cmd_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic [CHAR_W-1:0] ch;
  } fpe_dig_t;

  function automatic conv_t conv_code(input logic [CHAR_W-1:0] b);
    conv_t c;
    unique case (b)
      CH_C:       c = CV_CHR;
      CH_D, CH_I: c = CV_DEC;
      CH_U:       c = CV_UNS;
      CH_O:       c = CV_OCT;
      CH_X:       c = CV_HEX;
      CH_UX:      c = CV_HEXU;
      CH_P:       c = CV_PTR;
      default:    c = CV_NONE;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/fpe_numconv.sv =====
// Digit-serial number to text converter: shift-and-add-3 for decimal,
// digit shifting for octal and hex, leading zeros dropped. Uses fpe_pkg.
module fpe_numconv (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fpe_pkg::fpe_num_cmd_t     cmd,
  input  logic [fpe_pkg::ARG_W-1:0] value,
  input  logic                      take,
  output fpe_pkg::fpe_dig_t         dig
);
  import fpe_pkg::*;

  nc_state_t        st_r, st_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             oct_r, oct_nxt;
  logic             upper_r, upper_nxt;
  logic             skip_r, skip_nxt;

  logic [NUM_W-1:0] load_val;
  logic [CNT_W-1:0] load_cnt;
  logic [NUM_W-1:0] dab;
  logic [NUM_W-1:0] num_shift;
  logic [3:0]       top_dig;
  logic [CHAR_W-1:0] alpha;
  logic             hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= NC_IDLE;
      cnt_r  <= '0;
      skip_r <= 1'b1;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      skip_r <= skip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r   <= num_nxt;
    oct_r   <= oct_nxt;
    upper_r <= upper_nxt;
  end

  // octal/hex go to the top of num_r, decimal just under the BCD field
  always_comb begin
    load_val = '0;
    load_cnt = '0;
    unique case (cmd.kind)
      NK_DEC: begin
        load_val[NUM_W-DEC_W-1 -: INT_BITS] = value[INT_BITS-1:0];
        load_cnt = CNT_W'(INT_BITS);
      end
      NK_OCT: begin
        load_val[NUM_W-1 -: OCT_W] = OCT_W'(value[INT_BITS-1:0]);
        load_cnt = CNT_W'(OCT_DIGITS);
      end
      NK_HEXL, NK_HEXU: begin
        load_val[NUM_W-1 -: HEXI_W] = HEXI_W'(value[INT_BITS-1:0]);
        load_cnt = CNT_W'(HEXI_DIGITS);
      end
      NK_PTR: begin
        load_val[NUM_W-1 -: HEXP_W] = HEXP_W'(value[PTR_BITS-1:0]);
        load_cnt = CNT_W'(HEXP_DIGITS);
      end
      default: begin
        load_val = '0;
        load_cnt = '0;
      end
    endcase
  end

  // add 3 to every BCD nibble of 5 or more before the next shift
  always_comb begin
    dab = num_r;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (dab[NUM_W-1-4*i -: 4] >= 4'd5) begin
        dab[NUM_W-1-4*i -: 4] = dab[NUM_W-1-4*i -: 4] + 4'd3;
      end
    end
  end

  assign top_dig   = oct_r ? {1'b0, num_r[NUM_W-1 -: 3]} : num_r[NUM_W-1 -: 4];
  assign num_shift = oct_r ? (num_r << 3) : (num_r << 4);
  assign alpha     = upper_r ? CH_UA : CH_LA;
  assign hold      = skip_r && (top_dig == 4'd0) && (cnt_r != CNT_W'(1));

  always_comb begin
    st_nxt    = st_r;
    num_nxt   = num_r;
    cnt_nxt   = cnt_r;
    oct_nxt   = oct_r;
    upper_nxt = upper_r;
    skip_nxt  = skip_r;
    dig.valid = 1'b0;
    dig.last  = (cnt_r == CNT_W'(1));
    dig.ch    = (top_dig < 4'd10) ? (CH_ZERO + {4'b0, top_dig})
                                  : (alpha + {4'b0, top_dig} - 8'd10);
    unique case (st_r)
      NC_IDLE: begin
        if (cmd.load) begin
          num_nxt   = load_val;
          cnt_nxt   = load_cnt;
          oct_nxt   = (cmd.kind == NK_OCT);
          upper_nxt = (cmd.kind == NK_HEXU);
          skip_nxt  = 1'b1;
          st_nxt    = (cmd.kind == NK_DEC) ? NC_DABBLE : NC_OUT;
        end
      end
      NC_DABBLE: begin
        num_nxt = dab << 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          cnt_nxt = CNT_W'(DEC_DIGITS);
          st_nxt  = NC_OUT;
        end
      end
      NC_OUT: begin
        dig.valid = !hold;
        if (hold) begin
          num_nxt = num_shift;
          cnt_nxt = cnt_r - CNT_W'(1);
        end else if (take) begin
          num_nxt  = num_shift;
          cnt_nxt  = cnt_r - CNT_W'(1);
          skip_nxt = 1'b0;
          if (cnt_r == CNT_W'(1)) begin
            st_nxt = NC_IDLE;
          end
        end
      end
      default: st_nxt = NC_IDLE;
    endcase
  end

endmodule

// ===== rtl/format_print_engine.sv =====
// Streaming printf formatter: format bytes, argument words and string bytes in, characters out.
// Top level; uses fpe_pkg and fpe_numconv.
//
// Each transaction is taken in ST_IN and its results follow from an output
// register, with gaps while leading zeros are scanned. An unknown conversion
// echoes two characters. fpe_numconv drops leading zeros at one position per
// cycle. The first position is scanned in the cycle after the transaction,
// alongside any "0x" that is sent. Decimal conversion first runs
// shift-and-add-3 over the 32 value bits in fpe_numconv, overlapped with any
// '-' sign, and then scans 10 digit positions. A new transaction is taken once
// the last result of the previous one is in the output register; a stalled
// output holds the result and the counters and stops further results, but does
// not hold off the next transaction.
module format_print_engine (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [fpe_pkg::IN_TDATA_W-1:0]  in_tdata,   // byte_in[7:0], arg_word[71:8]
  input  logic [fpe_pkg::FUNC_W-1:0]      in_tuser,   // func[1:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fpe_pkg::OUT_TDATA_W-1:0] out_tdata,  // out_char[7:0], char_total[38:8], pad
  output logic [fpe_pkg::OUT_TUSER_W-1:0] out_tuser,  // char_valid, call_done, kind_error
  output logic                            out_tlast
);
  import fpe_pkg::*;

  top_state_t         st_r, st_nxt;
  parse_mode_t        mode_r, mode_nxt;
  conv_t              pend_r, pend_nxt;
  logic [TOTAL_W-1:0] count_r, count_nxt;
  logic [1:0]         nch_r, nch_nxt;
  logic               numf_r, numf_nxt;
  logic               done_r, done_nxt;
  logic               kerr_r, kerr_nxt;
  logic [CHAR_W-1:0]  ch0_r, ch0_nxt;
  logic [CHAR_W-1:0]  ch1_r, ch1_nxt;

  logic               ov_r, ov_nxt;
  logic [CHAR_W-1:0]  oc_r, oc_nxt;
  logic               ocv_r, ocv_nxt;
  logic               olast_r, olast_nxt;
  logic               odone_r, odone_nxt;
  logic               okerr_r, okerr_nxt;
  logic [TOTAL_W-1:0] ototal_r, ototal_nxt;

  // decode of the incoming transaction
  logic [FUNC_W-1:0]   func;
  logic [CHAR_W-1:0]   b;
  logic [ARG_W-1:0]    w;
  logic [INT_BITS-1:0] v;
  logic [INT_BITS-1:0] mag;
  logic [FUNC_W-1:0]   want;
  conv_t               conv;
  parse_mode_t         d_mode;
  conv_t               d_pend;
  logic [1:0]          d_nch;
  logic [CHAR_W-1:0]   d_ch0, d_ch1;
  logic                d_numf, d_done, d_kerr;
  logic                d_load;
  num_kind_t           d_kind;
  logic [ARG_W-1:0]    d_val;

  logic               in_fire;
  logic               free;
  logic               wr, wr_cv, wr_last;
  logic [CHAR_W-1:0]  wr_ch;
  logic [TOTAL_W-1:0] c_inc, c_after;
  logic               take;

  fpe_num_cmd_t       ncmd;
  fpe_dig_t           dig;

  fpe_numconv u_numconv (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (ncmd),
    .value (d_val),
    .take  (take),
    .dig   (dig)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IN;
      mode_r  <= PM_IDLE;
      pend_r  <= CV_NONE;
      count_r <= '0;
      nch_r   <= '0;
      numf_r  <= 1'b0;
      done_r  <= 1'b0;
      kerr_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      mode_r  <= mode_nxt;
      pend_r  <= pend_nxt;
      count_r <= count_nxt;
      nch_r   <= nch_nxt;
      numf_r  <= numf_nxt;
      done_r  <= done_nxt;
      kerr_r  <= kerr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch0_r    <= ch0_nxt;
    ch1_r    <= ch1_nxt;
    oc_r     <= oc_nxt;
    ocv_r    <= ocv_nxt;
    olast_r  <= olast_nxt;
    odone_r  <= odone_nxt;
    okerr_r  <= okerr_nxt;
    ototal_r <= ototal_nxt;
  end

  assign func = in_tuser;
  assign b    = in_tdata[CHAR_W-1:0];
  assign w    = in_tdata[CHAR_W+ARG_W-1:CHAR_W];
  assign v    = w[INT_BITS-1:0];
  // two's complement magnitude; the most negative value maps to itself
  assign mag  = v[INT_BITS-1] ? (~v + INT_BITS'(1)) : v;
  assign conv = conv_code(b);

  always_comb begin
    priority if (mode_r == PM_ARG) want = FUNC_ARG;
    else if (mode_r == PM_STR)     want = FUNC_STR;
    else                           want = FUNC_FMT;
  end

  always_comb begin
    d_mode = mode_r;
    d_pend = pend_r;
    d_nch  = 2'd0;
    d_ch0  = b;
    d_ch1  = b;
    d_numf = 1'b0;
    d_done = 1'b0;
    d_kerr = 1'b0;
    d_load = 1'b0;
    d_kind = NK_DEC;
    d_val  = w;
    if (func != want) begin
      d_kerr = 1'b1;
    end else begin
      unique case (mode_r)
        PM_IDLE: begin
          priority if (b == CH_NUL) d_done = 1'b1;
          else if (b == CH_PCT)     d_mode = PM_PCT;
          else                      d_nch  = 2'd1;
        end
        PM_PCT: begin
          d_mode = PM_IDLE;
          priority if (b == CH_NUL) begin
            d_nch  = 2'd1;
            d_ch0  = CH_PCT;
            d_done = 1'b1;
          end else if (b == CH_PCT) begin
            d_nch = 2'd1;
            d_ch0 = CH_PCT;
          end else if (b == CH_S) begin
            d_mode = PM_STR;
          end else if (conv != CV_NONE) begin
            d_pend = conv;
            d_mode = PM_ARG;
          end else begin
            // unknown conversion: echo '%' and the letter
            d_nch = 2'd2;
            d_ch0 = CH_PCT;
            d_ch1 = b;
          end
        end
        PM_ARG: begin
          d_mode = PM_IDLE;
          d_pend = CV_NONE;
          unique case (pend_r)
            CV_CHR: begin
              d_nch = 2'd1;
              d_ch0 = w[CHAR_W-1:0];
            end
            CV_DEC: begin
              d_nch  = v[INT_BITS-1] ? 2'd1 : 2'd0;
              d_ch0  = CH_MINUS;
              d_numf = 1'b1;
              d_load = 1'b1;
              d_kind = NK_DEC;
              d_val  = ARG_W'(mag);
            end
            CV_UNS: begin
              d_numf = 1'b1;
              d_load = 1'b1;
              d_kind = NK_DEC;
            end
            CV_OCT: begin
              d_numf = 1'b1;
              d_load = 1'b1;
              d_kind = NK_OCT;
            end
            CV_HEX: begin
              d_numf = 1'b1;
              d_load = 1'b1;
              d_kind = NK_HEXL;
            end
            CV_HEXU: begin
              d_numf = 1'b1;
              d_load = 1'b1;
              d_kind = NK_HEXU;
            end
            CV_PTR, CV_NONE: begin
              d_nch  = 2'd2;
              d_ch0  = CH_ZERO;
              d_ch1  = CH_X;
              d_numf = 1'b1;
              d_load = 1'b1;
              d_kind = NK_PTR;
            end
            default: d_nch = 2'd0;
          endcase
        end
        PM_STR: begin
          if (b == CH_NUL) d_mode = PM_IDLE;
          else             d_nch  = 2'd1;
        end
        default: d_mode = PM_IDLE;
      endcase
    end
    if (d_done) begin
      d_mode = PM_IDLE;
      d_pend = CV_NONE;
    end
  end

  assign in_fire   = in_tvalid && in_tready;
  assign ncmd.load = in_fire && d_load;
  assign ncmd.kind = d_kind;
  assign free      = !ov_r || out_tready;

  assign c_inc   = (count_r == TOTAL_MAX) ? count_r : (count_r + TOTAL_W'(1));
  assign c_after = wr_cv ? c_inc : count_r;

  always_comb begin
    st_nxt    = st_r;
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    nch_nxt   = nch_r;
    numf_nxt  = numf_r;
    done_nxt  = done_r;
    kerr_nxt  = kerr_r;
    ch0_nxt   = ch0_r;
    ch1_nxt   = ch1_r;
    in_tready = 1'b0;
    take      = 1'b0;
    wr        = 1'b0;
    wr_cv     = 1'b0;
    wr_last   = 1'b0;
    wr_ch     = CH_NUL;
    unique case (st_r)
      ST_IN: begin
        in_tready = 1'b1;
        if (in_fire) begin
          mode_nxt = d_mode;
          pend_nxt = d_pend;
          nch_nxt  = d_nch;
          numf_nxt = d_numf;
          done_nxt = d_done;
          kerr_nxt = d_kerr;
          ch0_nxt  = d_ch0;
          ch1_nxt  = d_ch1;
          st_nxt   = ST_CHR;
        end
      end
      ST_CHR: begin
        if (nch_r == 2'd0) begin
          if (numf_r) begin
            st_nxt = ST_NUM;
          end else if (free) begin
            // transaction with no character: one empty result
            wr      = 1'b1;
            wr_last = 1'b1;
            st_nxt  = ST_IN;
          end
        end else if (free) begin
          wr      = 1'b1;
          wr_cv   = 1'b1;
          wr_ch   = ch0_r;
          wr_last = (nch_r == 2'd1) && !numf_r;
          ch0_nxt = ch1_r;
          nch_nxt = nch_r - 2'd1;
          if (nch_r == 2'd1) begin
            st_nxt = numf_r ? ST_NUM : ST_IN;
          end
        end
      end
      ST_NUM: begin
        if (free && dig.valid) begin
          take    = 1'b1;
          wr      = 1'b1;
          wr_cv   = 1'b1;
          wr_ch   = dig.ch;
          wr_last = dig.last;
          if (dig.last) begin
            st_nxt = ST_IN;
          end
        end
      end
      default: st_nxt = ST_IN;
    endcase
  end

  // output register and character count
  always_comb begin
    ov_nxt     = ov_r;
    oc_nxt     = oc_r;
    ocv_nxt    = ocv_r;
    olast_nxt  = olast_r;
    odone_nxt  = odone_r;
    okerr_nxt  = okerr_r;
    ototal_nxt = ototal_r;
    count_nxt  = count_r;
    if (wr) begin
      ov_nxt     = 1'b1;
      oc_nxt     = wr_ch;
      ocv_nxt    = wr_cv;
      olast_nxt  = wr_last;
      odone_nxt  = wr_last && done_r;
      okerr_nxt  = wr_last && kerr_r;
      ototal_nxt = (wr_last && done_r) ? c_after : '0;
      count_nxt  = (wr_last && done_r) ? '0 : c_after;
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {1'b0, ototal_r, oc_r};
  assign out_tuser  = {okerr_r, odone_r, ocv_r};
  assign out_tlast  = olast_r;

endmodule
